// ===== hw/rtl/bms_pkg.sv =====
// Package for the block median select: item payload types and the
// command and status structs shared by the controller and the datapath.
// No dependencies.
`default_nettype none

package bms_pkg;

    // Input item: one Q16.16 sample and the end-of-block mark.
    typedef struct packed {
        logic signed [31:0] sample_value;
        logic               last_sample;
    } t_in_item;

    // Result item: median, kept count and overflow mark of one block.
    typedef struct packed {
        logic signed [31:0] median_value;
        logic [6:0]         sample_count;
        logic               overflow_flag;
    } t_out_item;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;     // latch the new sample, start the scan at the kept count
        logic drop;     // store is full: mark the block as overflowed
        logic rd_prev;  // read the entry just below the insertion point
        logic shift;    // move the entry read up by one place
        logic ins;      // write the sample at the insertion point, count it
        logic rd_mid;   // read the middle entry of the block
        logic emit;     // load the result register and clear the block
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic full;      // store holds the maximum number of samples
        logic pos_zero;  // insertion point is at the bottom of the store
        logic gt;        // entry read is greater than the new sample
        logic out_free;  // result register can take a new item this cycle
    } t_sts;

endpackage

`default_nettype wire

// ===== hw/rtl/bms_datapath.sv =====
// Datapath of the block median select: sorted sample memory, scan pointer,
// kept count, overflow mark and the result register.
// Depends on bms_pkg.
`default_nettype none

module bms_datapath #(
    parameter int MAX_LEN      = 64,
    parameter int SAMPLE_WIDTH = 32
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  bms_pkg::t_in_item i_in,
    input  bms_pkg::t_cmd     i_cmd,
    output bms_pkg::t_sts     o_sts,
    input  wire               i_out_ready,
    output logic              o_out_valid,
    output bms_pkg::t_out_item o_out
);
    import bms_pkg::*;

    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int CW = $clog2(MAX_LEN + 1);

    // Sorted store, ascending signed order, and its registered read data.
    logic [SAMPLE_WIDTH-1:0] mem [MAX_LEN];
    logic [SAMPLE_WIDTH-1:0] r_rdata;
    logic [SAMPLE_WIDTH-1:0] r_key;
    logic [AW-1:0]           r_pos;
    logic [AW-1:0]           n_pos;
    logic [CW-1:0]           r_count;
    logic [CW-1:0]           n_count;
    logic                    r_dropped;
    logic                    n_dropped;
    logic                    r_out_valid;
    t_out_item               r_out;

    logic                    w_wr_en;
    logic [SAMPLE_WIDTH-1:0] w_wr_data;
    logic                    w_rd_en;
    logic [AW-1:0]           w_rd_addr;

    // Write port: a shifted entry or the new sample, always at the scan pointer.
    assign w_wr_en   = i_cmd.shift | i_cmd.ins;
    assign w_wr_data = i_cmd.shift ? r_rdata : r_key;

    // Read port: the entry below the scan pointer, or the middle entry.
    assign w_rd_en   = i_cmd.rd_prev | i_cmd.rd_mid;
    assign w_rd_addr = i_cmd.rd_prev ? (r_pos - AW'(1)) : AW'(r_count >> 1);

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            mem[r_pos] <= w_wr_data;
        end
        if (w_rd_en) begin
            r_rdata <= mem[w_rd_addr];
        end
    end

    // Sample register; only bits below SAMPLE_WIDTH take part.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_key <= SAMPLE_WIDTH'($unsigned(i_in.sample_value));
        end
    end

    // Scan pointer starts at the kept count and walks down on each shift.
    always_comb begin
        n_pos = r_pos;
        if (i_cmd.load) begin
            n_pos = AW'(r_count);
        end else if (i_cmd.shift) begin
            n_pos = r_pos - AW'(1);
        end
    end

    // Kept count and overflow mark of the current block.
    always_comb begin
        n_count   = r_count;
        n_dropped = r_dropped;
        if (i_cmd.emit) begin
            n_count   = '0;
            n_dropped = 1'b0;
        end else begin
            if (i_cmd.ins) begin
                n_count = r_count + CW'(1);
            end
            if (i_cmd.drop) begin
                n_dropped = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_count   <= '0;
            r_dropped <= 1'b0;
        end else begin
            r_pos     <= n_pos;
            r_count   <= n_count;
            r_dropped <= n_dropped;
        end
    end

    // Result register; holds its item until the consumer takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out.median_value  <= 32'($unsigned(r_rdata));
            r_out.sample_count  <= 7'(r_count);
            r_out.overflow_flag <= r_dropped;
        end
    end

    // Status back to the controller.
    assign o_sts.full     = (r_count == CW'(MAX_LEN));
    assign o_sts.pos_zero = (r_pos == '0);
    assign o_sts.gt       = ($signed(r_rdata) > $signed(r_key));
    assign o_sts.out_free = ~r_out_valid | i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

`default_nettype wire

// ===== hw/rtl/bms_ctrl.sv =====
// Controller of the block median select: sequences the insertion scan,
// the median read and the hand-off to the result register.
// Depends on bms_pkg.
`default_nettype none

module bms_ctrl (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_in_valid,
    input  wire            i_last_sample,
    output logic           o_in_ready,
    input  bms_pkg::t_sts  i_sts,
    output bms_pkg::t_cmd  o_cmd
);
    import bms_pkg::*;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_SCAN     = 3'd1;
    localparam logic [2:0] S_CMP      = 3'd2;
    localparam logic [2:0] S_MID_RD   = 3'd3;
    localparam logic [2:0] S_MID_WAIT = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_last;
    logic       n_last;
    logic       w_accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid & o_in_ready;

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        n_last  = r_last;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_last = i_last_sample;
                    if (i_sts.full) begin
                        o_cmd.drop = 1'b1;
                        n_state    = i_last_sample ? S_MID_RD : S_IDLE;
                    end else begin
                        o_cmd.load = 1'b1;
                        n_state    = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (i_sts.pos_zero) begin
                    o_cmd.ins = 1'b1;
                    n_state   = r_last ? S_MID_RD : S_IDLE;
                end else begin
                    o_cmd.rd_prev = 1'b1;
                    n_state       = S_CMP;
                end
            end
            S_CMP: begin
                if (i_sts.gt) begin
                    o_cmd.shift = 1'b1;
                    n_state     = S_SCAN;
                end else begin
                    o_cmd.ins = 1'b1;
                    n_state   = r_last ? S_MID_RD : S_IDLE;
                end
            end
            S_MID_RD: begin
                o_cmd.rd_mid = 1'b1;
                n_state      = S_MID_WAIT;
            end
            S_MID_WAIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_last  <= n_last;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/block_median_select_top.sv =====
// Block median select: collects a block of signed Q16.16 samples into a
// sorted memory by insertion and, on the sample marked last, returns the
// element at sorted index count/2 with the kept count and an overflow mark.
// Samples beyond MAX_LEN are dropped. A new sample is taken only once the
// insertion scan of the previous one is done; the scan walks down past
// each kept sample greater than it. A marked item is followed by the median
// read before the next item is taken, and waits further while the result
// register is still full. Each step of the scan reads one entry of the
// sample memory into a read register and then writes one entry.
// Depends on bms_pkg, bms_ctrl and bms_datapath.
`default_nettype none

module block_median_select_top #(
    parameter int MAX_LEN      = 64,
    parameter int SAMPLE_WIDTH = 32
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    input  bms_pkg::t_in_item   i_in,
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    output bms_pkg::t_out_item  o_out
);
    import bms_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    // Sequencing.
    bms_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_last_sample (i_in.last_sample),
        .o_in_ready    (o_in_ready),
        .i_sts         (w_sts),
        .o_cmd         (w_cmd)
    );

    // Storage and arithmetic.
    bms_datapath #(
        .MAX_LEN      (MAX_LEN),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out       (o_out)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/bms_checker.sv =====
// Port-level checks for the block median select, attached to the top level
// by the bind statement at the end of this file.
// Depends on bms_pkg.
`default_nettype none

module bms_checker #(
    parameter int MAX_LEN = 64
) (
    input wire                i_clk,
    input wire                i_rst_n,
    input wire                o_out_valid,
    input wire                i_out_ready,
    input bms_pkg::t_out_item o_out
);
    import bms_pkg::*;

    // A block always keeps at least one sample.
    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((MAX_LEN > 127) || (o_out.sample_count != 7'd0)))
        else $error("result item with zero sample count");

    // The kept count never exceeds the store depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((MAX_LEN > 127) || (o_out.sample_count <= 7'(MAX_LEN))))
        else $error("sample count above store depth");

    // Samples are dropped only once the store is full.
    a_overflow_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.overflow_flag) |-> (o_out.sample_count == 7'(MAX_LEN)))
        else $error("overflow reported with store not full");

    // A stalled result item holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out)))
        else $error("stalled result item changed");

endmodule

bind block_median_select_top bms_checker #(.MAX_LEN(MAX_LEN)) u_bms_checker (.*);

`default_nettype wire

// ===== test/testbench.sv =====
// Testbench for block_median_select_top: streams blocks of Q16.16 samples in random bursts
// and checks each block's median, count and overflow mark against its own sorted copy.
// Depends on bms_pkg and block_median_select_top.
`default_nettype none

// Tracks the blocks in flight: keeps a sorted copy of the current block and
// queues the median result that each marked sample must produce.
class median_board #(int DEPTH = 64);
    logic signed [31:0]  sorted_samples [DEPTH];
    int                  kept;
    bit                  dropped;
    bms_pkg::t_out_item  medians_due[$];
    int                  n_taken;
    int                  n_errors;

    // Inserts an accepted sample after any equal ones, or drops it when full.
    function void note_sample(bms_pkg::t_in_item it);
        logic signed [31:0] v;
        int                 pos;
        bms_pkg::t_out_item due;
        v = it.sample_value;
        n_taken++;
        if (kept < DEPTH) begin
            pos = kept;
            while (pos > 0 && sorted_samples[pos - 1] > v) begin
                sorted_samples[pos] = sorted_samples[pos - 1];
                pos--;
            end
            sorted_samples[pos] = v;
            kept++;
        end else begin
            dropped = 1'b1;
        end
        // A marked sample closes the block: the upper median is queued.
        if (it.last_sample) begin
            due.median_value  = sorted_samples[kept / 2];
            due.sample_count  = 7'(kept);
            due.overflow_flag = dropped;
            medians_due.push_back(due);
            kept    = 0;
            dropped = 1'b0;
        end
    endfunction

    // Compares a delivered result with the oldest block still waiting.
    function void check_result(bms_pkg::t_out_item got);
        bms_pkg::t_out_item want;
        if (medians_due.size() == 0) begin
            $error("result with no block pending: median_value %0d", got.median_value);
            n_errors++;
            return;
        end
        want = medians_due.pop_front();
        if (got.median_value !== want.median_value) begin
            $error("median_value: expected %0d, got %0d", want.median_value, got.median_value);
            n_errors++;
        end
        if (got.sample_count !== want.sample_count) begin
            $error("sample_count: expected %0d, got %0d", want.sample_count, got.sample_count);
            n_errors++;
        end
        if (got.overflow_flag !== want.overflow_flag) begin
            $error("overflow_flag: expected %0d, got %0d", want.overflow_flag,
                   got.overflow_flag);
            n_errors++;
        end
    endfunction
endclass

module testbench;

    localparam int STORE_DEPTH = 64;
    localparam int ITEM_GOAL   = 750;
    localparam int DRAIN_WAIT  = 2 * STORE_DEPTH + 16;
    localparam int HOLD_START  = 300;
    localparam int HOLD_CYCLES = 400;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    bms_pkg::t_in_item  i_in;
    logic               o_out_valid;
    logic               i_out_ready;
    bms_pkg::t_out_item o_out;

    median_board #(STORE_DEPTH) board;

    int burst_left;

    block_median_select_top #(
        .MAX_LEN      (STORE_DEPTH),
        .SAMPLE_WIDTH (32)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    always #10 i_clk = ~i_clk;

    function automatic bms_pkg::t_in_item make_item(logic [31:0] v, logic last);
        bms_pkg::t_in_item it;
        it.sample_value = v;
        it.last_sample  = last;
        return it;
    endfunction

    // Picks a sample: full range, a narrow range that repeats values,
    // the extremes, or moderate Q16.16 values.
    function automatic logic [31:0] random_sample();
        logic [31:0] r;
        case ($urandom_range(0, 3))
            0: r = $urandom;
            1: r = $urandom_range(0, 6) - 3;
            2: begin
                case ($urandom_range(0, 4))
                    0: r = 32'h8000_0000;
                    1: r = 32'h7fff_ffff;
                    2: r = 32'h0000_0000;
                    3: r = 32'hffff_ffff;
                    default: r = 32'h0000_0001;
                endcase
            end
            default: r = $urandom_range(0, 32'd13107200) - 32'd6553600;
        endcase
        return r;
    endfunction

    // Offers one item and holds it until accepted; then either keeps valid
    // high for the next item of the burst or idles for a random gap.
    task automatic send_item(bms_pkg::t_in_item it);
        int gap;
        i_in_valid <= 1'b1;
        i_in       <= it;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        board.note_sample(it);
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // Sends a whole block of random samples with the mark on the last one.
    task automatic send_block(int len);
        for (int k = 0; k < len; k++) begin
            send_item(make_item(random_sample(), k == len - 1));
        end
    endtask

    // Result side: checks accepted results; ready steps through always-high, random,
    // mostly-low and toggling phases, with one long hold to back up the block.
    initial begin
        int  cyc;
        int  hold_left;
        bit  hold_done;
        logic next_ready;
        cyc        = 0;
        hold_left  = 0;
        hold_done  = 1'b0;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) begin
                board.check_result(o_out);
            end
            if (!hold_done && board.n_taken >= HOLD_START) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                next_ready = 1'b0;
                hold_left--;
            end else begin
                case ((cyc / 97) % 4)
                    0: next_ready = 1'b1;
                    1: next_ready = $urandom_range(0, 1);
                    2: next_ready = ($urandom_range(0, 3) == 0);
                    default: next_ready = cyc[2];
                endcase
            end
            i_out_ready <= next_ready;
            cyc++;
        end
    end

    // Sample side: reset, directed blocks, random blocks, then drain.
    initial begin
        int len;
        board      = new;
        burst_left = 1;
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in       <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Single-sample blocks at both extremes and zero.
        send_item(make_item(32'h8000_0000, 1'b1));
        send_item(make_item(32'h7fff_ffff, 1'b1));
        send_item(make_item(32'h0000_0000, 1'b1));
        // Even count: the upper of the two middle samples is returned.
        send_item(make_item(32'hffff_ffff, 1'b0));
        send_item(make_item(32'h0000_0001, 1'b1));
        // Descending order forces the longest scan per sample.
        send_item(make_item(32'h7fff_ffff, 1'b0));
        send_item(make_item(32'h0000_0000, 1'b0));
        send_item(make_item(32'h8000_0000, 1'b1));
        // Equal samples.
        send_item(make_item(32'h0005_0000, 1'b0));
        send_item(make_item(32'h0005_0000, 1'b0));
        send_item(make_item(32'h0005_0000, 1'b0));
        send_item(make_item(32'h0005_0000, 1'b1));
        // Mixed signs around the middle, alternating bit patterns.
        send_item(make_item(32'h8000_0000, 1'b0));
        send_item(make_item(32'h7fff_ffff, 1'b0));
        send_item(make_item(32'hffff_ffff, 1'b0));
        send_item(make_item(32'h0001_0000, 1'b1));
        send_item(make_item(32'haaaa_aaaa, 1'b0));
        send_item(make_item(32'h5555_5555, 1'b0));
        send_item(make_item(32'h5555_5555, 1'b0));
        send_item(make_item(32'haaaa_aaaa, 1'b0));
        send_item(make_item(32'hffff_0000, 1'b1));

        // Random blocks: mostly short, some that fill the store exactly or
        // overflow it, including a marked sample that is itself dropped.
        while (board.n_taken < ITEM_GOAL) begin
            if ($urandom_range(0, 11) == 0) begin
                case ($urandom_range(0, 2))
                    0: len = STORE_DEPTH;
                    1: len = STORE_DEPTH + 1;
                    default: len = $urandom_range(STORE_DEPTH + 2, STORE_DEPTH + 16);
                endcase
            end else begin
                len = $urandom_range(1, 10);
            end
            send_block(len);
        end
        i_in_valid <= 1'b0;

        while (board.medians_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (board.n_errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // Watchdog for a block that stops handing over items.
    initial begin
        #20000000;
        $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
hw/rtl/bms_pkg.sv
hw/rtl/bms_datapath.sv
hw/rtl/bms_ctrl.sv
hw/rtl/block_median_select_top.sv
hw/rtl/bms_checker.sv
test/testbench.sv
